// ===== rtl/skgt_pkg.sv =====
// Package for the sorted key group table: sizes, status codes and sequencer states.
// Used by sorted_key_group_table_unit. Depends on nothing.
package skgt_pkg;

  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned KEY_BITS     = 8;
  localparam int unsigned PAYLOAD_BITS = 16;

  // Fixed port field widths
  localparam int unsigned IN_KEY_W  = 8;
  localparam int unsigned IN_PAY_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // Smallest key group that counts as paired
  localparam int unsigned MIN_GROUP = 2;
  localparam int unsigned RUN_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ===== rtl/sorted_key_group_table_unit.sv =====
// Sorted key group table: one result word per input word, table kept in one RAM.
// Steps from accept to result: scan (one RAM read per entry, RAM read latency, end check),
// tail, result load.
// One word at a time: in_tready is low for the whole pass, so the next word is taken only
// after the result is loaded, and later while an earlier result still waits.
// Reset (rst_n low, synchronous): table empty, sequencer idle, no result pending.
module sorted_key_group_table_unit #(
  parameter int unsigned CAPACITY     = skgt_pkg::CAPACITY,
  parameter int unsigned KEY_BITS     = skgt_pkg::KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = skgt_pkg::PAYLOAD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input: tdata = key[7:0], payload[23:8]; tuser = kind (0 insert, 1 delete)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [skgt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  // result: tdata = status[1:0], removed_count[9:2], occupancy[17:10],
  //         groups_ready[18], zero[23:19]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skgt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned RUN_W = skgt_pkg::RUN_W;
  localparam int unsigned PAD_W = skgt_pkg::OUT_DATA_W - skgt_pkg::STATUS_W
                                  - 2 * skgt_pkg::COUNT_W - 1;

  // Entry packing in RAM: key in the low bits, payload above
  skgt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;     // occupancy
  logic [CNT_W-1:0] issue_r, issue_nxt;     // next RAM read index
  logic [CNT_W-1:0] wr_r, wr_nxt;           // next write index = entries emitted
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic             vld_r, vld_nxt;         // read data valid this cycle
  logic             placed_r, placed_nxt;   // new entry already emitted
  logic             bad_r, bad_nxt;         // a finished group had < MIN_GROUP
  logic [RUN_W-1:0] run_r, run_nxt;         // current group length, saturating
  logic             del_r, del_nxt;
  logic             full_r, full_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers (no reset)
  logic [KEY_BITS-1:0]             key_r, key_nxt;
  logic [ENT_W-1:0]                new_ent_r, new_ent_nxt;
  logic [ENT_W-1:0]                pend_r, pend_nxt;   // entry displaced by insert
  logic [KEY_BITS-1:0]             prev_key_r, prev_key_nxt;
  logic [skgt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // RAM port
  logic             ram_we;
  logic [ENT_W-1:0] ram_rdata;
  logic [KEY_BITS-1:0] rd_key;

  // Emit: at most one entry of the resulting table goes out, in order, per cycle
  logic             emit_v;
  logic [ENT_W-1:0] emit_e;
  logic [KEY_BITS-1:0] emit_key;

  logic                        ready_flag;
  skgt_pkg::status_t           status;

  skgt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_r[AW-1:0]),
    .wdata(emit_e),
    .raddr(issue_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_key    = ram_rdata[KEY_BITS-1:0];
  assign emit_key  = emit_e[KEY_BITS-1:0];
  assign in_tready = (state_r == skgt_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    wr_nxt        = wr_r;
    removed_nxt   = removed_r;
    vld_nxt       = vld_r;
    placed_nxt    = placed_r;
    bad_nxt       = bad_r;
    run_nxt       = run_r;
    del_nxt       = del_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    new_ent_nxt   = new_ent_r;
    pend_nxt      = pend_r;
    prev_key_nxt  = prev_key_r;
    out_data_nxt  = out_data_r;
    emit_v        = 1'b0;
    emit_e        = pend_r;
    ram_we        = 1'b0;
    ready_flag    = 1'b0;
    status        = skgt_pkg::ST_DONE;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      skgt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          del_nxt     = in_tuser;
          key_nxt     = KEY_BITS'(in_tdata[skgt_pkg::IN_KEY_W-1:0]);
          new_ent_nxt = {PAYLOAD_BITS'(in_tdata[skgt_pkg::IN_DATA_W-1:skgt_pkg::IN_KEY_W]),
                         KEY_BITS'(in_tdata[skgt_pkg::IN_KEY_W-1:0])};
          full_nxt    = !in_tuser && (count_r == CNT_W'(CAPACITY));
          issue_nxt   = '0;
          wr_nxt      = '0;
          removed_nxt = '0;
          vld_nxt     = 1'b0;
          placed_nxt  = 1'b0;
          bad_nxt     = 1'b0;
          run_nxt     = '0;
          state_nxt   = skgt_pkg::S_SCAN;
        end
      end
      skgt_pkg::S_SCAN: begin
        // read stream runs one index ahead of the processing
        if (issue_r < count_r) begin
          issue_nxt = issue_r + 1'b1;
          vld_nxt   = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (vld_r) begin
          if (del_r) begin
            if (rd_key == key_r) begin
              removed_nxt = removed_r + 1'b1;
            end else begin
              emit_v = 1'b1;
              emit_e = ram_rdata;
            end
          end else if (placed_r) begin
            // shift up: write the held entry one slot above its old place
            emit_v   = 1'b1;
            emit_e   = pend_r;
            pend_nxt = ram_rdata;
          end else if (!full_r && rd_key >= key_r) begin
            // new entry goes in front of equal and larger keys
            emit_v     = 1'b1;
            emit_e     = new_ent_r;
            pend_nxt   = ram_rdata;
            placed_nxt = 1'b1;
          end else begin
            emit_v = 1'b1;
            emit_e = ram_rdata;
          end
        end
        if (issue_r == count_r && !vld_r) begin
          state_nxt = skgt_pkg::S_TAIL;
        end
      end
      skgt_pkg::S_TAIL: begin
        if (!del_r && !full_r) begin
          emit_v = 1'b1;
          emit_e = placed_r ? pend_r : new_ent_r;
        end
        state_nxt = skgt_pkg::S_DONE;
      end
      skgt_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          ready_flag = (wr_r != '0) && !bad_r && (run_r >= RUN_W'(skgt_pkg::MIN_GROUP));
          if (full_r) begin
            status = skgt_pkg::ST_FULL;
          end else if (del_r && removed_r == '0) begin
            status = skgt_pkg::ST_ABSENT;
          end else begin
            status = skgt_pkg::ST_DONE;
          end
          out_data_nxt  = {{PAD_W{1'b0}}, ready_flag,
                           skgt_pkg::COUNT_W'(wr_r),
                           skgt_pkg::COUNT_W'(removed_r),
                           status};
          out_valid_nxt = 1'b1;
          count_nxt     = wr_r;
          state_nxt     = skgt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skgt_pkg::S_IDLE;
      end
    endcase

    // Every emitted entry is written back (except on a full insert) and
    // feeds the group-length tracker in final table order.
    if (emit_v) begin
      ram_we       = !full_r;
      wr_nxt       = wr_r + 1'b1;
      prev_key_nxt = emit_key;
      if (wr_r == '0) begin
        run_nxt = RUN_W'(1);
      end else if (emit_key == prev_key_r) begin
        if (run_r < RUN_W'(skgt_pkg::MIN_GROUP)) begin
          run_nxt = run_r + 1'b1;
        end
      end else begin
        if (run_r < RUN_W'(skgt_pkg::MIN_GROUP)) begin
          bad_nxt = 1'b1;
        end
        run_nxt = RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skgt_pkg::S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      wr_r        <= '0;
      removed_r   <= '0;
      vld_r       <= 1'b0;
      placed_r    <= 1'b0;
      bad_r       <= 1'b0;
      run_r       <= '0;
      del_r       <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      wr_r        <= wr_nxt;
      removed_r   <= removed_nxt;
      vld_r       <= vld_nxt;
      placed_r    <= placed_nxt;
      bad_r       <= bad_nxt;
      run_r       <= run_nxt;
      del_r       <= del_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    new_ent_r  <= new_ent_nxt;
    pend_r     <= pend_nxt;
    prev_key_r <= prev_key_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/skgt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read of the address being written returns the old word. No dependencies.
module skgt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
